/* rtl/goniometer_point_mapper_unit_macros.svh */
// ----------------------------------------------------------------------------
// Goniometer point mapper assertion macros
// Shared concurrent assertion forms for the point mapper RTL.
// ----------------------------------------------------------------------------
`ifndef GONIOMETER_POINT_MAPPER_UNIT_MACROS_SVH
`define GONIOMETER_POINT_MAPPER_UNIT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define GPM_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define GPM_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/gpm_pkg.sv */
// ----------------------------------------------------------------------------
// Goniometer point mapper package
// Widths, constants, register codes, the square root step and the geometry
// rounding shared by the point mapper RTL.
// ----------------------------------------------------------------------------
package gpm_pkg;

	// Field widths.
	localparam int SAMPLE_BITS = 16;
	localparam int CFG_W       = 16;
	localparam int MODE_W      = 2;
	localparam int NDC_W       = 16;
	localparam int BRIGHT_W    = 13;

	// Register port.
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN         = 3'd0,
		REG_ROT_COS      = 3'd1,
		REG_ROT_SIN      = 3'd2,
		REG_GEOM_MODE    = 3'd3,
		REG_ASPECT       = 3'd4,
		REG_ASPECT_RECIP = 3'd5
	} reg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		GEOM_RASTER = 2'd0,
		GEOM_CIRCLE = 2'd1,
		GEOM_SEMI   = 2'd2
	} geom_mode_t;

	// Register reset values.
	localparam logic [CFG_W-1:0]  GAIN_RST   = 16'd4096;
	localparam logic [CFG_W-1:0]  ROT_COS_RST = 16'd16384;
	localparam logic [CFG_W-1:0]  ROT_SIN_RST = 16'd0;
	localparam logic [CFG_W-1:0]  ASPECT_RST = 16'd4096;
	localparam logic [CFG_W-1:0]  RECIP_RST  = 16'd32768;

	// Scale by 1/sqrt2 (Q0.16) and gain, rounded to Q.20.
	localparam int K_W      = 17;
	localparam logic signed [K_W-1:0] K_SCALE = 17'sd46341;
	localparam int P1_W     = SAMPLE_BITS + K_W;
	localparam int P2_W     = P1_W + CFG_W + 1;
	localparam int SCALE_SH = SAMPLE_BITS + 5;
	localparam logic signed [P2_W-1:0] SCALE_HALF = P2_W'(1) << (SCALE_SH - 1);
	localparam int X_W      = 27;

	// Rotation in Q1.14.
	localparam int M_W    = X_W + CFG_W;
	localparam int ROT_W  = M_W + 1;
	localparam int ROT_SH = 14;
	localparam logic signed [ROT_W-1:0] ROT_HALF = ROT_W'(1) << (ROT_SH - 1);
	localparam int R_W    = X_W + 2;

	// Geometry fit.
	localparam int F_W = R_W + 1;
	localparam int G_W = F_W + CFG_W + 1;
	localparam int N_W = 35;
	localparam logic [CFG_W-1:0] ASPECT_ONE = 16'd4096;
	localparam logic [CFG_W-1:0] ASPECT_TWO = 16'd8192;
	localparam logic [CFG_W-1:0] MUL_UNIT   = 16'd4096;
	localparam logic [CFG_W-1:0] MUL_DOUBLE = 16'd8192;
	localparam logic signed [N_W-1:0] ONE_Q20 = N_W'(1) << 20;

	typedef enum logic [1:0] {
		SHIFT_12 = 2'd0,
		SHIFT_14 = 2'd1,
		SHIFT_15 = 2'd2
	} shift_t;

	// Screen output, Q.20 to Q.12 with saturation.
	localparam int NDC_SH = 8;
	localparam logic signed [N_W-1:0] NDC_HALF = N_W'(1) << (NDC_SH - 1);
	localparam logic signed [N_W-1:0] NDC_MAX  = N_W'((1 << (NDC_W - 1)) - 1);
	localparam logic signed [N_W-1:0] NDC_MIN  = -(N_W'(1) << (NDC_W - 1));

	// Magnitude and square root.
	localparam int SQ_W       = 2 * R_W;
	localparam int SQ_SAT_SH  = 40;
	localparam int RT_DROP    = 16;
	localparam int RT_W       = SQ_SAT_SH - RT_DROP;
	localparam int RT_STEPS   = RT_W / 2;
	localparam int RT_PER_ST  = 2;
	localparam int RT_STAGES  = RT_STEPS / RT_PER_ST;
	localparam logic [BRIGHT_W-1:0] BRIGHT_ONE = 13'd4096;

	// Pipeline layout: seven arithmetic stages, then the root stages.
	localparam int RT_FIRST   = 8;
	localparam int NUM_STAGES = RT_FIRST - 1 + RT_STAGES;

	typedef struct packed {
		logic [RT_W-1:0] rem;
		logic [RT_W-1:0] root;
	} rt_pair_t;

	// One digit of the bitwise integer square root.
	function automatic rt_pair_t rt_step(rt_pair_t cur, logic [RT_W-1:0] bit_v);
		logic [RT_W:0] trial;
		rt_pair_t      nxt;
		trial = {1'b0, cur.root} + {1'b0, bit_v};
		if ({1'b0, cur.rem} >= trial) begin
			nxt.rem  = cur.rem - trial[RT_W-1:0];
			nxt.root = (cur.root >> 1) + bit_v;
		end else begin
			nxt.rem  = cur.rem;
			nxt.root = cur.root >> 1;
		end
		return nxt;
	endfunction

	// Round half up of a geometry product by the selected shift.
	function automatic logic signed [N_W-1:0] round_geo(logic signed [G_W-1:0] p, shift_t sh);
		logic signed [G_W-1:0] t;
		unique case (sh)
			SHIFT_14: begin
				t = (p + G_W'(1 << 13)) >>> 14;
			end
			SHIFT_15: begin
				t = (p + G_W'(1 << 14)) >>> 15;
			end
			default: begin
				t = (p + G_W'(1 << 11)) >>> 12;
			end
		endcase
		return t[N_W-1:0];
	endfunction

endpackage

/* rtl/gpm_ifs.sv */
// ----------------------------------------------------------------------------
// Goniometer point mapper channels
// Valid/ready channels for field points in and screen points out.
// ----------------------------------------------------------------------------
interface gpm_in_if import gpm_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] point_x;
	logic signed [SAMPLE_BITS-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface gpm_out_if import gpm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [NDC_W-1:0] ndc_x;
	logic signed [NDC_W-1:0] ndc_y;
	logic [BRIGHT_W-1:0]     brightness;

	modport source (output valid, output ndc_x, output ndc_y, output brightness, input ready);
	modport sink (input valid, input ndc_x, input ndc_y, input brightness, output ready);
endinterface

/* rtl/goniometer_point_mapper_unit.sv */
// ----------------------------------------------------------------------------
// Goniometer point mapper
// Scales, rotates and fits one stereo field point to screen coordinates and
// computes its brightness.
// ----------------------------------------------------------------------------
// The unit takes one field point per clock while the output side keeps ready
// high, and returns one screen point per field point, in order. The pipeline
// has two multiply stages for scaling, a rounding stage, two for rotation, two
// that form the squares and the geometry products, and a square root that
// resolves two result bits in each of six stages, alongside which the geometry
// result is rounded and saturated. Any empty stage is filled while the output
// is stalled, so points keep entering until the pipeline is full. Registers are
// written over the APB port and must only change while no point is in flight.
`include "goniometer_point_mapper_unit_macros.svh"

module goniometer_point_mapper_unit import gpm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	gpm_in_if.sink             points,
	gpm_out_if.source          screen
);

	// Configuration registers.
	logic [CFG_W-1:0]  gain_q;
	logic [CFG_W-1:0]  rot_cos_q;
	logic [CFG_W-1:0]  rot_sin_q;
	logic [MODE_W-1:0] geom_mode_q;
	logic [CFG_W-1:0]  aspect_q;
	logic [CFG_W-1:0]  aspect_recip_q;
	logic              cfg_wr;

	// Pipeline control.
	logic [NUM_STAGES:1] vld_s;
	logic [NUM_STAGES:1] vld_in;
	logic [NUM_STAGES:1] en;

	// Stage data.
	logic signed [P1_W-1:0]  mx_s1, my_s1;
	logic signed [P2_W-1:0]  gx_s2, gy_s2;
	logic signed [X_W-1:0]   x_s3, y_s3;
	logic signed [M_W-1:0]   xc_s4, ys_s4, xs_s4, yc_s4;
	logic signed [R_W-1:0]   rx_s5, ry_s5;
	logic [SQ_W-1:0]         xx_s6, yy_s6;
	logic signed [F_W-1:0]   fx_s6, fy_s6;
	logic [CFG_W-1:0]        mulx_s6, muly_s6;
	shift_t                  shx_s6, shy_s6, shx_s7, shy_s7;
	logic                    sub_s6, sub_s7;
	logic signed [G_W-1:0]   px_s7, py_s7;
	logic signed [N_W-1:0]   gnx_s8, gny_s8;
	rt_pair_t                rt_s [RT_STAGES+1];
	logic                    sat_s [RT_STAGES+1];
	logic signed [NDC_W-1:0] ndc_x_s [2:RT_STAGES];
	logic signed [NDC_W-1:0] ndc_y_s [2:RT_STAGES];

	// Combinational helpers.
	logic signed [P1_W-1:0]  mx_d, my_d;
	logic signed [P2_W-1:0]  gx_d, gy_d, rnd_x_d, rnd_y_d;
	logic signed [M_W-1:0]   xc_d, ys_d, xs_d, yc_d;
	logic signed [ROT_W-1:0] rot_x_d, rot_y_d;
	logic signed [SQ_W-1:0]  xx_d, yy_d;
	logic signed [F_W-1:0]   fx_d, fy_d;
	logic [CFG_W-1:0]        mulx_d, muly_d;
	shift_t                  shx_d, shy_d;
	logic                    sub_d;
	logic signed [G_W-1:0]   px_d, py_d;
	logic [SQ_W:0]           sq_d;
	logic signed [N_W-1:0]   gnx_d, gny_d, nx_d, ny_d;
	logic signed [NDC_W-1:0] ndc_x_d, ndc_y_d;
	rt_pair_t                rt_nxt [1:RT_STAGES];

	// Assertion terms.
	logic bright_ok;
	logic root_rem_ok;
	logic stall_hold;

	// ------------------------------------------------------------------
	// Register port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q         <= GAIN_RST;
			rot_cos_q      <= ROT_COS_RST;
			rot_sin_q      <= ROT_SIN_RST;
			geom_mode_q    <= GEOM_CIRCLE;
			aspect_q       <= ASPECT_RST;
			aspect_recip_q <= RECIP_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[PADDR_W-1:2]))
				REG_GAIN:         gain_q         <= pwdata[CFG_W-1:0];
				REG_ROT_COS:      rot_cos_q      <= pwdata[CFG_W-1:0];
				REG_ROT_SIN:      rot_sin_q      <= pwdata[CFG_W-1:0];
				REG_GEOM_MODE:    geom_mode_q    <= pwdata[MODE_W-1:0];
				REG_ASPECT:       aspect_q       <= pwdata[CFG_W-1:0];
				REG_ASPECT_RECIP: aspect_recip_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[PADDR_W-1:2]))
			REG_GAIN:         prdata = PDATA_W'(gain_q);
			REG_ROT_COS:      prdata = PDATA_W'(rot_cos_q);
			REG_ROT_SIN:      prdata = PDATA_W'(rot_sin_q);
			REG_GEOM_MODE:    prdata = PDATA_W'(geom_mode_q);
			REG_ASPECT:       prdata = PDATA_W'(aspect_q);
			REG_ASPECT_RECIP: prdata = PDATA_W'(aspect_recip_q);
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow: a stage loads when it is empty or its successor moves.
	// ------------------------------------------------------------------
	always_comb begin
		en[NUM_STAGES] = !vld_s[NUM_STAGES] || screen.ready;
		for (int s = NUM_STAGES - 1; s >= 1; s--) begin
			en[s] = !vld_s[s] || en[s+1];
		end
	end

	assign vld_in = {vld_s[NUM_STAGES-1:1], points.valid};
	assign points.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int s = 1; s <= NUM_STAGES; s++) begin
				if (en[s]) begin
					vld_s[s] <= vld_in[s];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stages 1 to 3: scale by 1/sqrt2 and gain, round to Q.20.
	// ------------------------------------------------------------------
	assign mx_d = points.point_x * K_SCALE;
	assign my_d = points.point_y * K_SCALE;
	assign gx_d = mx_s1 * $signed({1'b0, gain_q});
	assign gy_d = my_s1 * $signed({1'b0, gain_q});
	assign rnd_x_d = (gx_s2 + SCALE_HALF) >>> SCALE_SH;
	assign rnd_y_d = (gy_s2 + SCALE_HALF) >>> SCALE_SH;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mx_s1 <= mx_d;
			my_s1 <= my_d;
		end
		if (en[2]) begin
			gx_s2 <= gx_d;
			gy_s2 <= gy_d;
		end
		if (en[3]) begin
			x_s3 <= rnd_x_d[X_W-1:0];
			y_s3 <= rnd_y_d[X_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stages 4 and 5: rotation products, then sums rounded back to Q.20.
	// ------------------------------------------------------------------
	assign xc_d = x_s3 * $signed(rot_cos_q);
	assign ys_d = y_s3 * $signed(rot_sin_q);
	assign xs_d = x_s3 * $signed(rot_sin_q);
	assign yc_d = y_s3 * $signed(rot_cos_q);
	assign rot_x_d = (ROT_W'(xc_s4) - ROT_W'(ys_s4) + ROT_HALF) >>> ROT_SH;
	assign rot_y_d = (ROT_W'(xs_s4) + ROT_W'(yc_s4) + ROT_HALF) >>> ROT_SH;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			xc_s4 <= xc_d;
			ys_s4 <= ys_d;
			xs_s4 <= xs_d;
			yc_s4 <= yc_d;
		end
		if (en[5]) begin
			rx_s5 <= rot_x_d[R_W-1:0];
			ry_s5 <= rot_y_d[R_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: squares for the magnitude, and the geometry operands.
	// Each axis is later multiplied and rounded by a chosen shift; a pass
	// through is a multiply by one in Q.12, doubling a multiply by two.
	// ------------------------------------------------------------------
	assign xx_d = rx_s5 * rx_s5;
	assign yy_d = ry_s5 * ry_s5;

	always_comb begin
		fx_d   = F_W'(rx_s5);
		fy_d   = F_W'(ry_s5);
		mulx_d = MUL_UNIT;
		muly_d = MUL_UNIT;
		shx_d  = SHIFT_12;
		shy_d  = SHIFT_12;
		sub_d  = 1'b0;
		unique case (geom_mode_t'(geom_mode_q))
			GEOM_SEMI: begin
				// Fold the lower half up, then fit the half disc.
				if (ry_s5 < 0) begin
					fx_d = -F_W'(rx_s5);
					fy_d = -F_W'(ry_s5);
				end
				sub_d = 1'b1;
				if (aspect_q > ASPECT_TWO) begin
					mulx_d = aspect_recip_q;
					shx_d  = SHIFT_14;
					muly_d = MUL_DOUBLE;
				end else if (aspect_q != '0) begin
					muly_d = aspect_q;
				end
			end
			GEOM_CIRCLE: begin
				// Shrink the wide axis.
				if (aspect_q > ASPECT_ONE) begin
					mulx_d = aspect_recip_q;
					shx_d  = SHIFT_15;
				end else if (aspect_q != '0) begin
					muly_d = aspect_q;
				end
			end
			GEOM_RASTER: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			xx_s6   <= xx_d;
			yy_s6   <= yy_d;
			fx_s6   <= fx_d;
			fy_s6   <= fy_d;
			mulx_s6 <= mulx_d;
			muly_s6 <= muly_d;
			shx_s6  <= shx_d;
			shy_s6  <= shy_d;
			sub_s6  <= sub_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: geometry products, magnitude sum and its cap.
	// ------------------------------------------------------------------
	assign px_d = fx_s6 * $signed({1'b0, mulx_s6});
	assign py_d = fy_s6 * $signed({1'b0, muly_s6});
	assign sq_d = {1'b0, xx_s6} + {1'b0, yy_s6};

	always_ff @(posedge clk) begin
		if (en[7]) begin
			px_s7  <= px_d;
			py_s7  <= py_d;
			shx_s7 <= shx_s6;
			shy_s7 <= shy_s6;
			sub_s7 <= sub_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stages 8 and 9: round the geometry to Q.20, then to saturated Q.12.
	// ------------------------------------------------------------------
	assign gnx_d = round_geo(px_s7, shx_s7);
	assign gny_d = round_geo(py_s7, shy_s7) - (sub_s7 ? ONE_Q20 : '0);
	assign nx_d  = (gnx_s8 + NDC_HALF) >>> NDC_SH;
	assign ny_d  = (gny_s8 + NDC_HALF) >>> NDC_SH;

	always_comb begin
		if (nx_d > NDC_MAX) begin
			ndc_x_d = NDC_MAX[NDC_W-1:0];
		end else if (nx_d < NDC_MIN) begin
			ndc_x_d = NDC_MIN[NDC_W-1:0];
		end else begin
			ndc_x_d = nx_d[NDC_W-1:0];
		end
		if (ny_d > NDC_MAX) begin
			ndc_y_d = NDC_MAX[NDC_W-1:0];
		end else if (ny_d < NDC_MIN) begin
			ndc_y_d = NDC_MIN[NDC_W-1:0];
		end else begin
			ndc_y_d = ny_d[NDC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[RT_FIRST]) begin
			gnx_s8 <= gnx_d;
			gny_s8 <= gny_d;
		end
		if (en[RT_FIRST+1]) begin
			ndc_x_s[2] <= ndc_x_d;
			ndc_y_s[2] <= ndc_y_d;
		end
		for (int k = 3; k <= RT_STAGES; k++) begin
			if (en[RT_FIRST-1+k]) begin
				ndc_x_s[k] <= ndc_x_s[k-1];
				ndc_y_s[k] <= ndc_y_s[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stages 8 to 13: square root of the magnitude, two bits per stage.
	// The root operand and the cap flag are loaded in stage 7.
	// ------------------------------------------------------------------
	always_comb begin
		rt_pair_t cur;
		for (int k = 1; k <= RT_STAGES; k++) begin
			cur = rt_s[k-1];
			for (int m = 0; m < RT_PER_ST; m++) begin
				cur = rt_step(cur, RT_W'(1) << (RT_W - 2 - 2 * ((k - 1) * RT_PER_ST + m)));
			end
			rt_nxt[k] = cur;
		end
	end

	always_ff @(posedge clk) begin
		if (en[RT_FIRST-1]) begin
			sat_s[0]     <= |sq_d[SQ_W:SQ_SAT_SH];
			rt_s[0].rem  <= sq_d[SQ_SAT_SH-1:RT_DROP];
			rt_s[0].root <= '0;
		end
		for (int k = 1; k <= RT_STAGES; k++) begin
			if (en[RT_FIRST-1+k]) begin
				rt_s[k]  <= rt_nxt[k];
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Output beat.
	// ------------------------------------------------------------------
	assign screen.valid      = vld_s[NUM_STAGES];
	assign screen.ndc_x      = ndc_x_s[RT_STAGES];
	assign screen.ndc_y      = ndc_y_s[RT_STAGES];
	assign screen.brightness = sat_s[RT_STAGES] ? BRIGHT_ONE :
		{1'b0, rt_s[RT_STAGES].root[BRIGHT_W-2:0]};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	assign bright_ok   = screen.brightness <= BRIGHT_ONE;
	assign root_rem_ok = rt_s[RT_STAGES].rem <= (rt_s[RT_STAGES].root << 1);
	assign stall_hold  = vld_s[RT_FIRST] && !en[RT_FIRST];

	`GPM_ASSERT_IMP(a_bright_cap, clk, arst_n, screen.valid, bright_ok, "brightness above one")
	`GPM_ASSERT_IMP(a_root_rem, clk, arst_n, vld_s[NUM_STAGES], root_rem_ok, "root remainder")
	`GPM_ASSERT_NEXT(a_held_stage, clk, arst_n, stall_hold, vld_s[RT_FIRST], "stalled point lost")

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Goniometer point mapper testbench
// Drives field points through the mapper under a range of register settings
// and compares every screen point with an independent fixed-point prediction.
// Both channel sides idle at random, and the registers are read back over APB.
// ----------------------------------------------------------------------------
module testbench import gpm_pkg::*; ();

	typedef longint unsigned u64_t;

	// Register shadow, one field per register.
	typedef struct packed {
		logic [CFG_W-1:0]  gain;
		logic [CFG_W-1:0]  rot_cos;
		logic [CFG_W-1:0]  rot_sin;
		logic [MODE_W-1:0] mode;
		logic [CFG_W-1:0]  aspect;
		logic [CFG_W-1:0]  recip;
	} mapper_cfg_t;

	typedef struct packed {
		logic signed [NDC_W-1:0] ndc_x;
		logic signed [NDC_W-1:0] ndc_y;
		logic [BRIGHT_W-1:0]     brightness;
	} screen_pt_t;

	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          DRAIN_CYCLES  = 40;
	localparam int          REPORT_LIMIT  = 10;
	localparam int unsigned IDLE_MAX      = 7;
	localparam int          NUM_REGS      = 6;
	localparam int          RANDOM_PHASES = 10;
	localparam int          PHASE_POINTS  = 95;
	localparam longint      INV_SQRT2_Q16 = 46341;
	localparam longint      NDC_TOP       = 32767;
	localparam longint      NDC_BOTTOM    = -32768;
	localparam int          SAT_SHIFT     = 40;
	localparam int          ROOT_DROP     = 16;
	localparam int          ROOT_MSB      = 11;
	localparam int          FIT_SHIFT_12  = 12;
	localparam int          FIT_SHIFT_14  = 14;
	localparam int          FIT_SHIFT_15  = 15;
	localparam int          Q20_BITS      = 20;

	// Register indexes past the last register; writes there are dropped.
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	// Mode code with no geometry of its own.
	localparam logic [MODE_W-1:0]    GEOM_SPARE   = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	gpm_in_if  points_if ();
	gpm_out_if screen_if ();

	mapper_cfg_t cfg;
	screen_pt_t  expected_screen[$];
	int          fail_count = 0;
	int          cycle_count = 0;
	int          screen_beats = 0;
	bit          idle_off = 1'b0;

	goniometer_point_mapper_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.points  (points_if),
		.screen  (screen_if)
	);

	// Free-running clock with a period of two time units.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Counts a failure and prints the first few.
	task automatic report_failure(string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("ERROR: %s", msg);
		end
	endtask

	// ------------------------------------------------------------------------
	// Screen point prediction
	// ------------------------------------------------------------------------

	// Rounds half up while dropping sh fraction bits.
	function automatic longint round_half_up(longint v, int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	// Largest r with r*r <= n, for n below 2^24.
	function automatic logic [BRIGHT_W-1:0] root_floor(u64_t n);
		u64_t r;
		u64_t t;
		r = 0;
		for (int b = ROOT_MSB; b >= 0; b--) begin
			t = r | (u64_t'(1) << b);
			if (t * t <= n) begin
				r = t;
			end
		end
		return BRIGHT_W'(r);
	endfunction

	// Q.20 to Q.12 with saturation to the screen range.
	function automatic logic signed [NDC_W-1:0] ndc_clamp(longint v20);
		longint v;
		v = round_half_up(v20, NDC_SH);
		if (v > NDC_TOP) begin
			v = NDC_TOP;
		end else if (v < NDC_BOTTOM) begin
			v = NDC_BOTTOM;
		end
		return NDC_W'(v);
	endfunction

	function automatic screen_pt_t predict_screen(logic signed [SAMPLE_BITS-1:0] px,
			logic signed [SAMPLE_BITS-1:0] py);
		longint     x;
		longint     y;
		longint     rx;
		longint     ry;
		longint     g;
		longint     c;
		longint     s;
		longint     asp;
		longint     rec;
		longint     a;
		u64_t       sq;
		screen_pt_t res;
		g   = longint'(cfg.gain);
		c   = longint'($signed(cfg.rot_cos));
		s   = longint'($signed(cfg.rot_sin));
		asp = longint'(cfg.aspect);
		rec = longint'(cfg.recip);

		// Scale by 1/sqrt2 and the gain down to Q.20, then rotate.
		x  = round_half_up(longint'(px) * INV_SQRT2_Q16 * g, SAMPLE_BITS + 5);
		y  = round_half_up(longint'(py) * INV_SQRT2_Q16 * g, SAMPLE_BITS + 5);
		rx = round_half_up(x * c - y * s, FIT_SHIFT_14);
		ry = round_half_up(x * s + y * c, FIT_SHIFT_14);
		x  = rx;
		y  = ry;

		// Magnitude of the rotated point, capped at one.
		sq = u64_t'(x * x) + u64_t'(y * y);
		if (sq >= (u64_t'(1) << SAT_SHIFT)) begin
			res.brightness = BRIGHT_ONE;
		end else begin
			res.brightness = root_floor(sq >> ROOT_DROP);
		end

		// Geometry fit for the selected mode.
		case (cfg.mode)
			GEOM_SEMI: begin
				// The lower half folds upward; a point on the axis stays put.
				if (y < 0) begin
					x = -x;
					y = -y;
				end
				if (asp > longint'(ASPECT_TWO)) begin
					x = round_half_up(x * rec, FIT_SHIFT_14);
					y = 2 * y - (longint'(1) << Q20_BITS);
				end else begin
					a = (asp > 0) ? asp : longint'(ASPECT_ONE);
					y = round_half_up(y * a, FIT_SHIFT_12) - (longint'(1) << Q20_BITS);
				end
			end
			GEOM_CIRCLE: begin
				if (asp > longint'(ASPECT_ONE)) begin
					x = round_half_up(x * rec, FIT_SHIFT_15);
				end else if (asp > 0) begin
					y = round_half_up(y * asp, FIT_SHIFT_12);
				end
			end
			default: begin
				// Raster and the spare code pass the point through.
			end
		endcase

		res.ndc_x = ndc_clamp(x);
		res.ndc_y = ndc_clamp(y);
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Register port
	// ------------------------------------------------------------------------

	function automatic logic [CFG_W-1:0] shadow_reg(logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_GAIN:         return cfg.gain;
			REG_ROT_COS:      return cfg.rot_cos;
			REG_ROT_SIN:      return cfg.rot_sin;
			REG_GEOM_MODE:    return CFG_W'(cfg.mode);
			REG_ASPECT:       return cfg.aspect;
			REG_ASPECT_RECIP: return cfg.recip;
			default:          return '0;
		endcase
	endfunction

	// Setup and access phases, then an idle phase; the upper data bits carry noise.
	task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		logic [PDATA_W-1:0] data;
		data    = {(PDATA_W - CFG_W)'($urandom), value};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_GAIN:         cfg.gain    = value;
			REG_ROT_COS:      cfg.rot_cos = value;
			REG_ROT_SIN:      cfg.rot_sin = value;
			REG_GEOM_MODE:    cfg.mode    = value[MODE_W-1:0];
			REG_ASPECT:       cfg.aspect  = value;
			REG_ASPECT_RECIP: cfg.recip   = value;
			default: begin
				// Writes past the register file change nothing.
			end
		endcase
		@(posedge clk);
	endtask

	task automatic apb_read(logic [REG_IDX_W-1:0] idx, output logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data    = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Reads every register back and compares its used bits with the shadow.
	task automatic check_registers();
		logic [PDATA_W-1:0]   rd;
		logic [CFG_W-1:0]     want;
		logic [REG_IDX_W-1:0] idx;
		bit                   ok;
		for (int i = 0; i < NUM_REGS; i++) begin
			idx  = REG_IDX_W'(i);
			want = shadow_reg(idx);
			apb_read(idx, rd);
			if (idx == REG_GEOM_MODE) begin
				ok = (rd[MODE_W-1:0] === want[MODE_W-1:0]);
			end else begin
				ok = (rd[CFG_W-1:0] === want);
			end
			if (!ok) begin
				report_failure($sformatf("register %0d read %h, expected %h", i, rd, want));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Point channel
	// ------------------------------------------------------------------------

	// Offers one field point and records its prediction once the beat is taken.
	task automatic send_point(logic signed [SAMPLE_BITS-1:0] px,
			logic signed [SAMPLE_BITS-1:0] py);
		int unsigned gap;
		gap = idle_off ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap > 0) begin
			points_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		points_if.valid   <= 1'b1;
		points_if.point_x <= px;
		points_if.point_y <= py;
		@(posedge clk);
		while (points_if.ready !== 1'b1) @(posedge clk);
		expected_screen = {expected_screen, predict_screen(px, py)};
	endtask

	// Drops valid right after the last beat and waits for every result.
	task automatic settle();
		if (points_if.valid !== 1'b0) begin
			points_if.valid <= 1'b0;
		end
		while (expected_screen.size() != 0) @(posedge clk);
	endtask

	// Registers change only with nothing in flight.
	task automatic set_config(logic [CFG_W-1:0] gain, logic [CFG_W-1:0] rot_cos,
			logic [CFG_W-1:0] rot_sin, logic [MODE_W-1:0] mode,
			logic [CFG_W-1:0] aspect, logic [CFG_W-1:0] recip);
		settle();
		apb_write(REG_GAIN, gain);
		apb_write(REG_ROT_COS, rot_cos);
		apb_write(REG_ROT_SIN, rot_sin);
		apb_write(REG_GEOM_MODE, CFG_W'(mode));
		apb_write(REG_ASPECT, aspect);
		apb_write(REG_ASPECT_RECIP, recip);
	endtask

	// Mostly unit-range samples, some full-scale and some tiny ones.
	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 3))
			0:       return SAMPLE_BITS'($urandom);
			3:       return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
			default: return SAMPLE_BITS'(int'($urandom_range(0, 16383)) - 8192);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] random_rotation();
		case ($urandom_range(0, 3))
			2: begin
				case ($urandom_range(0, 2))
					0:       return CFG_W'(16384);
					1:       return CFG_W'(-16384);
					default: return '0;
				endcase
			end
			3:       return CFG_W'($urandom);
			default: return CFG_W'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	task automatic random_config();
		logic [CFG_W-1:0]  gain;
		logic [CFG_W-1:0]  aspect;
		logic [CFG_W-1:0]  recip;
		logic [MODE_W-1:0] mode;
		case ($urandom_range(0, 3))
			0:       gain = CFG_W'($urandom);
			1:       gain = CFG_W'($urandom_range(2048, 8192));
			2:       gain = ($urandom_range(0, 1) != 0) ? CFG_W'(65535) : '0;
			default: gain = CFG_W'(4096);
		endcase
		case ($urandom_range(0, 5))
			0:       aspect = '0;
			1:       aspect = ASPECT_ONE;
			2:       aspect = ASPECT_TWO;
			3:       aspect = CFG_W'($urandom_range(1, 4095));
			4:       aspect = CFG_W'($urandom_range(4097, 65535));
			default: aspect = CFG_W'($urandom);
		endcase
		case ($urandom_range(0, 2))
			0:       recip = CFG_W'($urandom_range(0, 32768));
			1:       recip = CFG_W'($urandom);
			default: recip = ($urandom_range(0, 1) != 0) ? CFG_W'(32768) : '0;
		endcase
		mode = MODE_W'($urandom_range(0, 3));
		set_config(gain, random_rotation(), random_rotation(), mode, aspect, recip);
	endtask

	// ------------------------------------------------------------------------
	// Screen channel: random stalls, and every beat is checked in order.
	// ------------------------------------------------------------------------
	initial begin : screen_sink
		int unsigned stall;
		screen_pt_t  got;
		screen_pt_t  want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_off ? 0 : $urandom_range(0, IDLE_MAX);
			if (stall > 0) begin
				screen_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			screen_if.ready <= 1'b1;
			@(posedge clk);
			while (screen_if.valid !== 1'b1) @(posedge clk);
			got.ndc_x      = screen_if.ndc_x;
			got.ndc_y      = screen_if.ndc_y;
			got.brightness = screen_if.brightness;
			if (expected_screen.size() == 0) begin
				report_failure($sformatf("screen beat %0d with no point outstanding: x %0d y %0d b %0d",
					screen_beats, got.ndc_x, got.ndc_y, got.brightness));
			end else begin
				want = expected_screen.pop_front();
				if (got.ndc_x !== want.ndc_x || got.ndc_y !== want.ndc_y ||
						got.brightness !== want.brightness) begin
					report_failure($sformatf(
						"screen beat %0d: got x %0d y %0d b %0d, expected x %0d y %0d b %0d",
						screen_beats, got.ndc_x, got.ndc_y, got.brightness,
						want.ndc_x, want.ndc_y, want.brightness));
				end
			end
			screen_beats++;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset values read back, and a few points through the reset setup.
	task automatic test_reset_values();
		check_registers();
		send_point(0, 0);
		send_point(32767, 32767);
		send_point(-32768, -32768);
		send_point(8192, 0);
		settle();
	endtask

	// Random register contents read back; writes past the last register drop.
	task automatic test_register_access();
		for (int round = 0; round < 4; round++) begin
			apb_write(REG_GAIN, CFG_W'($urandom));
			apb_write(REG_ROT_COS, CFG_W'($urandom));
			apb_write(REG_ROT_SIN, CFG_W'($urandom));
			apb_write(REG_GEOM_MODE, CFG_W'($urandom));
			apb_write(REG_ASPECT, CFG_W'($urandom));
			apb_write(REG_ASPECT_RECIP, CFG_W'($urandom));
			check_registers();
			apb_write(REG_SPARE_LO, CFG_W'($urandom));
			apb_write(REG_SPARE_HI, CFG_W'($urandom));
			check_registers();
		end
	endtask

	// Field extremes and each geometry corner.
	task automatic test_directed_points();
		// Raster with full gain drives both axes into saturation.
		set_config(16'hFFFF, 16'd16384, 16'd0, GEOM_RASTER, ASPECT_ONE, 16'd32768);
		send_point(32767, -32768);
		send_point(-32768, 32767);
		send_point(1, -1);

		// Semicircle on a wide screen: fold below the axis, none on it.
		set_config(16'd4096, 16'd16384, 16'd0, GEOM_SEMI, 16'd16384, 16'd8192);
		send_point(1000, -2000);
		send_point(3000, 0);
		send_point(-500, 700);

		// Semicircle with an unset aspect, then one of exactly two.
		set_config(16'd4096, 16'd16384, 16'd0, GEOM_SEMI, 16'd0, 16'd0);
		send_point(2000, -3000);
		send_point(0, 0);
		set_config(16'd4096, 16'd16384, 16'd0, GEOM_SEMI, ASPECT_TWO, 16'd16384);
		send_point(4000, 4000);

		// Full circle: wide, tall and unset aspect.
		set_config(16'd4096, 16'd16384, 16'd0, GEOM_CIRCLE, 16'd20000, 16'd6711);
		send_point(5000, -5000);
		send_point(-8192, 8192);
		set_config(16'd4096, 16'd16384, 16'd0, GEOM_CIRCLE, 16'd2048, 16'hFFFF);
		send_point(6000, 6000);
		set_config(16'd4096, 16'd16384, 16'd0, GEOM_CIRCLE, 16'd0, 16'd32768);
		send_point(7000, -7000);

		// Spare mode code with rotation values beyond unit magnitude.
		set_config(16'd4096, 16'd32767, 16'h8000, GEOM_SPARE, ASPECT_ONE, 16'd32768);
		send_point(8191, -8191);
		send_point(-100, 50);

		// Zero gain collapses everything onto the origin.
		set_config(16'd0, 16'hC000, 16'd16384, GEOM_RASTER, ASPECT_ONE, 16'd32768);
		send_point(32767, 32767);
		settle();
	endtask

	// Random points under a series of settings, the extremes first.
	task automatic test_random_points();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0) begin
				set_config(16'hFFFF, 16'd16384, 16'd16384, GEOM_SEMI, 16'hFFFF, 16'd32768);
			end else if (phase == 1) begin
				set_config(16'd4096, 16'hC000, 16'hC000, GEOM_CIRCLE, 16'd1, 16'd0);
			end else begin
				random_config();
			end
			// Every fourth phase runs both sides without idling.
			idle_off = (phase % 4 == 3);
			for (int n = 0; n < PHASE_POINTS; n++) begin
				send_point(random_sample(), random_sample());
			end
			settle();
		end
		idle_off = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		points_if.valid   <= 1'b0;
		points_if.point_x <= '0;
		points_if.point_y <= '0;
		screen_if.ready   <= 1'b0;
		cfg.gain          = GAIN_RST;
		cfg.rot_cos       = ROT_COS_RST;
		cfg.rot_sin       = ROT_SIN_RST;
		cfg.mode          = GEOM_CIRCLE;
		cfg.aspect        = ASPECT_RST;
		cfg.recip         = RECIP_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_register_access();
		test_directed_points();
		test_random_points();

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_screen.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
